[rtl/icobd_pkg.sv]
// icobd_pkg: status codes, default sizes and the png signature for the icon decoder
// no dependencies; imported by ico_bitmap_decoder, ico_bitmap_decoder_chk and ico_bitmap_decoder_tb
package icobd_pkg;

  localparam int DEF_MAX_FILE_BYTES = 262144;
  localparam int DEF_MAX_ICONS      = 20;

  typedef logic [2:0] status_t;
  localparam status_t ST_BMP    = 3'd0;
  localparam status_t ST_PNG    = 3'd1;
  localparam status_t ST_BADHDR = 3'd2;
  localparam status_t ST_NOIMG  = 3'd3;
  localparam status_t ST_DEPTH  = 3'd4;
  localparam status_t ST_RANGE  = 3'd5;
  localparam status_t ST_ACCEPT = 3'd6;

  typedef logic [1:0] action_t;
  localparam action_t A_LOAD = 2'd0;
  localparam action_t A_PIX  = 2'd1;
  localparam action_t A_PNG  = 2'd2;

  function automatic logic [7:0] png_sig_byte(input logic [2:0] i);
    logic [7:0] b;
    unique case (i)
      3'd0: b = 8'h89;
      3'd1: b = 8'h50;
      3'd2: b = 8'h4E;
      3'd3: b = 8'h47;
      3'd4: b = 8'h0D;
      3'd5: b = 8'h0A;
      3'd6: b = 8'h1A;
      3'd7: b = 8'h0A;
    endcase
    return b;
  endfunction

endpackage

[rtl/ico_bitmap_decoder.sv]
// ico_bitmap_decoder: icon file loader, directory parser and pixel / png byte server
// depends on icobd_pkg and icobd_store
//
// channel  direction  handshake             payload
// in       sink       in_valid / in_ready   action file_byte final_byte pixel_x pixel_y
//                                           resource_index
// out      source     out_valid / out_ready status image_width image_height data_length
//                                           red green blue alpha png_byte
//
// every byte fetched from the store passes an address state and a data state (S_FETCH, S_DATA)
// on its single read port. one item is worked at a time; the next transfer is taken while a result
// waits in the output register. no clearing pass: reads never go past the loaded byte count.
// reset is synchronous and clears control state; the store itself is not cleared.
module ico_bitmap_decoder import icobd_pkg::*; #(
  parameter int MAX_FILE_BYTES = DEF_MAX_FILE_BYTES,
  parameter int MAX_ICONS      = DEF_MAX_ICONS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [7:0]  file_byte,
  input  logic        final_byte,
  input  logic [7:0]  pixel_x,
  input  logic [7:0]  pixel_y,
  input  logic [17:0] resource_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [8:0]  image_width,
  output logic [8:0]  image_height,
  output logic [18:0] data_length,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [7:0]  alpha,
  output logic [7:0]  png_byte
);

  localparam int AW  = $clog2(MAX_FILE_BYTES);
  localparam int LW  = $clog2(MAX_FILE_BYTES + 1);
  localparam int EW  = AW + 10;
  localparam int CLW = (LW > 19) ? LW : 19;
  localparam int IW  = $clog2(MAX_ICONS + 1);

  typedef enum logic [15:0] {
    S_IDLE   = 16'h0001,
    S_FETCH  = 16'h0002,
    S_DATA   = 16'h0004,
    S_HCHK   = 16'h0008,
    S_AREA   = 16'h0010,
    S_CMP    = 16'h0020,
    S_OFF    = 16'h0040,
    S_SIGCHK = 16'h0080,
    S_DCHK   = 16'h0100,
    S_PA     = 16'h0200,
    S_PB     = 16'h0400,
    S_PC     = 16'h0800,
    S_MA     = 16'h1000,
    S_MB     = 16'h2000,
    S_MC     = 16'h4000,
    S_EMIT   = 16'h8000
  } state_t;

  typedef enum logic [3:0] {
    P_HDR, P_EW, P_EH, P_EL, P_EO, P_SIG, P_B39, P_BIH, P_DEP,
    X_PIX, X_IDX, X_PAL, X_MASK, R_PNG
  } step_t;

  state_t          state;
  step_t           ret;
  logic [LW-1:0]   lc;
  logic [LW-1:0]   lc_eff;
  logic            file_done;
  logic [8:0]      cw;
  logic [8:0]      ch;
  logic [AW-1:0]   co;
  logic [CLW-1:0]  cl;
  logic [5:0]      pd;
  logic            mask_present;
  status_t         ds;
  logic            parsing;

  logic [EW-1:0]   addr;
  logic [2:0]      bcnt;
  logic [31:0]     acc;
  logic [31:0]     acc_next;
  logic            hdr_bad;
  logic            sig_ok;
  logic [IW-1:0]   cnt;
  logic [IW-1:0]   ei;
  logic [7:0]      w_t;
  logic [7:0]      h_t;
  logic [8:0]      wv;
  logic [8:0]      hv;
  logic [8:0]      cand_w;
  logic [8:0]      cand_h;
  logic [16:0]     area_r;
  logic [16:0]     best;
  logic [8:0]      bw;
  logic [8:0]      bh;
  logic [31:0]     off_r;
  logic [31:0]     len_r;
  logic [31:0]     el_t;
  logic [31:0]     bih_t;
  logic [15:0]     hdr_cnt;
  logic [15:0]     dv;

  logic [7:0]      px;
  logic [7:0]      py;
  logic [7:0]      row;
  logic [10:0]     stride;
  logic [5:0]      mstride;
  logic [EW-1:0]   base;
  logic [EW-1:0]   prod;
  logic [EW-1:0]   mbase;
  logic [EW-1:0]   rp;
  logic [EW-1:0]   ncol4;
  logic [EW-1:0]   pal;
  logic [7:0]      idx;
  logic [2:0]      bitsel;
  logic [7:0]      pr;
  logic [7:0]      pg;
  logic [7:0]      pbl;
  logic [7:0]      pa;
  logic [7:0]      pngb;
  logic            pix_ok;
  logic            png_ok;
  status_t         res_st;

  logic            store_we;
  logic [7:0]      rdata;

  assign in_ready = (state == S_IDLE);
  assign lc_eff   = file_done ? '0 : lc;
  assign store_we = in_valid && in_ready && (action == A_LOAD)
                    && (lc_eff < LW'(MAX_FILE_BYTES));
  assign acc_next = {rdata, acc[31:8]};
  assign wv       = (w_t == 8'd0) ? 9'd256 : {1'b0, w_t};
  assign hv       = (h_t == 8'd0) ? 9'd256 : {1'b0, h_t};
  assign hdr_cnt  = acc[31:16];
  assign dv       = acc[31:16];
  assign rp       = base + prod;
  assign pal      = EW'(co) + EW'(40);
  assign bitsel   = 3'd7 - px[2:0];

  always_comb begin
    priority if (pd == 6'd1) begin
      ncol4 = EW'(8);
    end else if (pd == 6'd4) begin
      ncol4 = EW'(64);
    end else if (pd == 6'd8) begin
      ncol4 = EW'(1024);
    end else begin
      ncol4 = '0;
    end
  end

  always_comb begin
    priority if (pd == 6'd8) begin
      idx = rdata;
    end else if (pd == 6'd4) begin
      idx = px[0] ? {4'd0, rdata[3:0]} : {4'd0, rdata[7:4]};
    end else begin
      idx = {7'd0, rdata[bitsel]};
    end
  end

  icobd_store #(
    .DEPTH (MAX_FILE_BYTES),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (lc_eff[AW-1:0]),
    .wdata (file_byte),
    .raddr (addr[AW-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      lc           <= '0;
      file_done    <= 1'b0;
      cw           <= '0;
      ch           <= '0;
      co           <= '0;
      cl           <= '0;
      pd           <= '0;
      mask_present <= 1'b0;
      ds           <= ST_NOIMG;
      out_valid    <= 1'b0;
      parsing      <= 1'b0;
    end else begin
      // the emit state refills the output register itself
      if (out_valid && out_ready && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            pix_ok <= 1'b0;
            png_ok <= 1'b0;
            px     <= pixel_x;
            py     <= pixel_y;
            pa     <= 8'd255;
            unique case (action)
              A_LOAD: begin
                if (file_done) begin
                  cw <= '0; ch <= '0; co <= '0; cl <= '0; pd <= '0;
                  mask_present <= 1'b0;
                  ds        <= ST_NOIMG;
                  file_done <= 1'b0;
                end
                if (lc_eff < LW'(MAX_FILE_BYTES)) begin
                  lc     <= lc_eff + LW'(1);
                  res_st <= ST_ACCEPT;
                end else begin
                  lc     <= lc_eff;
                  res_st <= ST_RANGE;
                end
                if (final_byte) begin
                  cw <= '0; ch <= '0; co <= '0; cl <= '0; pd <= '0;
                  mask_present <= 1'b0;
                  file_done <= 1'b1;
                  parsing   <= 1'b1;
                  addr      <= '0;
                  bcnt      <= '0;
                  hdr_bad   <= 1'b0;
                  ret       <= P_HDR;
                  state     <= S_FETCH;
                end else begin
                  state <= S_EMIT;
                end
              end
              A_PIX: begin
                parsing <= 1'b0;
                if (ds != ST_BMP) begin
                  res_st <= (ds == ST_PNG) ? ST_NOIMG : ds;
                  state  <= S_EMIT;
                end else if ({1'b0, pixel_x} >= cw || {1'b0, pixel_y} >= ch) begin
                  res_st <= ST_RANGE;
                  state  <= S_EMIT;
                end else begin
                  state <= S_PA;
                end
              end
              A_PNG: begin
                parsing <= 1'b0;
                if (ds != ST_PNG) begin
                  res_st <= (ds == ST_BMP) ? ST_NOIMG : ds;
                  state  <= S_EMIT;
                end else if (CLW'(resource_index) >= cl) begin
                  res_st <= ST_RANGE;
                  state  <= S_EMIT;
                end else begin
                  addr  <= EW'(co) + EW'(resource_index);
                  ret   <= R_PNG;
                  state <= S_FETCH;
                end
              end
              default: begin
                res_st <= ST_RANGE;
                state  <= S_EMIT;
              end
            endcase
          end
        end

        S_FETCH: begin
          // any byte at or past the loaded count ends the item as out of range
          if (addr >= EW'(lc)) begin
            res_st <= ST_RANGE;
            if (parsing) begin
              ds <= ST_RANGE;
            end
            state <= S_EMIT;
          end else begin
            state <= S_DATA;
          end
        end

        S_DATA: begin
          acc   <= acc_next;
          bcnt  <= bcnt + 3'd1;
          state <= S_FETCH;
          unique case (ret)
            P_HDR: begin
              if (bcnt == 3'd2) begin
                if (rdata != 8'd1) hdr_bad <= 1'b1;
              end else if (bcnt < 3'd4) begin
                if (rdata != 8'd0) hdr_bad <= 1'b1;
              end
              if (bcnt == 3'd5) begin
                state <= S_HCHK;
              end else begin
                addr <= addr + EW'(1);
              end
            end
            P_EW: begin
              w_t  <= rdata;
              addr <= addr + EW'(1);
              ret  <= P_EH;
            end
            P_EH: begin
              h_t  <= rdata;
              addr <= addr + EW'(7);
              bcnt <= '0;
              ret  <= P_EL;
            end
            P_EL: begin
              addr <= addr + EW'(1);
              if (bcnt == 3'd3) begin
                el_t <= acc_next;
                bcnt <= '0;
                ret  <= P_EO;
              end
            end
            P_EO: begin
              if (bcnt == 3'd3) begin
                state <= S_AREA;
              end else begin
                addr <= addr + EW'(1);
              end
            end
            P_SIG: begin
              sig_ok <= sig_ok && (rdata == png_sig_byte(bcnt));
              if (bcnt == 3'd7) begin
                state <= S_SIGCHK;
              end else begin
                addr <= addr + EW'(1);
              end
            end
            P_B39: begin
              addr <= EW'(off_r[AW-1:0]) + EW'(8);
              bcnt <= '0;
              ret  <= P_BIH;
            end
            P_BIH: begin
              if (bcnt == 3'd3) begin
                bih_t <= acc_next;
                addr  <= addr + EW'(3);
                bcnt  <= '0;
                ret   <= P_DEP;
              end else begin
                addr <= addr + EW'(1);
              end
            end
            P_DEP: begin
              if (bcnt == 3'd1) begin
                state <= S_DCHK;
              end else begin
                addr <= addr + EW'(1);
              end
            end
            X_PIX: begin
              addr <= addr + EW'(1);
              unique case (bcnt)
                3'd0: pbl <= rdata;
                3'd1: pg  <= rdata;
                3'd2: pr  <= rdata;
                default: pa <= rdata;
              endcase
              if ((bcnt == 3'd2 && pd == 6'd24) || bcnt == 3'd3) begin
                if (mask_present) begin
                  state <= S_MA;
                end else begin
                  pix_ok <= 1'b1;
                  res_st <= ST_BMP;
                  state  <= S_EMIT;
                end
              end
            end
            X_IDX: begin
              addr <= pal + EW'({idx, 2'b00});
              bcnt <= '0;
              ret  <= X_PAL;
            end
            X_PAL: begin
              addr <= addr + EW'(1);
              unique case (bcnt)
                3'd0: pbl <= rdata;
                3'd1: pg  <= rdata;
                default: pr <= rdata;
              endcase
              if (bcnt == 3'd2) begin
                if (mask_present) begin
                  state <= S_MA;
                end else begin
                  pix_ok <= 1'b1;
                  res_st <= ST_BMP;
                  state  <= S_EMIT;
                end
              end
            end
            X_MASK: begin
              if (rdata[bitsel]) begin
                pa <= 8'd0;
              end
              pix_ok <= 1'b1;
              res_st <= ST_BMP;
              state  <= S_EMIT;
            end
            R_PNG: begin
              pngb   <= rdata;
              png_ok <= 1'b1;
              res_st <= ST_PNG;
              state  <= S_EMIT;
            end
            default: begin
              state <= S_IDLE;
            end
          endcase
        end

        S_HCHK: begin
          if (hdr_bad || hdr_cnt == 16'd0 || hdr_cnt > 16'(MAX_ICONS)) begin
            ds     <= ST_BADHDR;
            res_st <= ST_BADHDR;
            state  <= S_EMIT;
          end else begin
            cnt   <= IW'(hdr_cnt);
            ei    <= '0;
            best  <= '0;
            off_r <= '0;
            len_r <= '0;
            bw    <= '0;
            bh    <= '0;
            addr  <= EW'(6);
            ret   <= P_EW;
            state <= S_FETCH;
          end
        end

        S_AREA: begin
          area_r <= 17'(wv * hv);
          cand_w <= wv;
          cand_h <= hv;
          state  <= S_CMP;
        end

        S_CMP: begin
          // strict compare keeps the first entry on a tie
          if (area_r > best) begin
            best  <= area_r;
            bw    <= cand_w;
            bh    <= cand_h;
            off_r <= acc;
            len_r <= el_t;
          end
          ei <= ei + IW'(1);
          if (ei + IW'(1) == cnt) begin
            state <= S_OFF;
          end else begin
            addr  <= addr + EW'(1);
            ret   <= P_EW;
            state <= S_FETCH;
          end
        end

        S_OFF: begin
          if (off_r == 32'd0) begin
            ds     <= ST_NOIMG;
            res_st <= ST_NOIMG;
            state  <= S_EMIT;
          end else if (off_r >= 32'(lc)) begin
            ds     <= ST_RANGE;
            res_st <= ST_RANGE;
            state  <= S_EMIT;
          end else begin
            addr   <= EW'(off_r[AW-1:0]);
            bcnt   <= '0;
            sig_ok <= 1'b1;
            ret    <= P_SIG;
            state  <= S_FETCH;
          end
        end

        S_SIGCHK: begin
          if (sig_ok) begin
            if (len_r == 32'd0) begin
              ds     <= ST_NOIMG;
              res_st <= ST_NOIMG;
            end else if ({1'b0, off_r} + {1'b0, len_r} > 33'(lc)) begin
              ds     <= ST_RANGE;
              res_st <= ST_RANGE;
            end else begin
              cw     <= bw;
              ch     <= bh;
              co     <= off_r[AW-1:0];
              cl     <= CLW'(len_r);
              ds     <= ST_PNG;
              res_st <= ST_PNG;
            end
            state <= S_EMIT;
          end else begin
            addr  <= EW'(off_r[AW-1:0]) + EW'(39);
            ret   <= P_B39;
            state <= S_FETCH;
          end
        end

        S_DCHK: begin
          if (dv != 16'd32 && dv != 16'd24 && dv != 16'd8 && dv != 16'd4 && dv != 16'd1) begin
            ds     <= ST_DEPTH;
            res_st <= ST_DEPTH;
          end else begin
            cw           <= bw;
            ch           <= bh;
            co           <= off_r[AW-1:0];
            cl           <= CLW'({best, 2'b00});
            pd           <= dv[5:0];
            mask_present <= (dv < 16'd32) && (bih_t != 32'(bh));
            ds           <= ST_BMP;
            res_st       <= ST_BMP;
          end
          state <= S_EMIT;
        end

        S_PA: begin
          // rows are stored bottom up, each padded to 32 bits
          row     <= 8'(ch - 9'd1 - {1'b0, py});
          stride  <= 11'(((16'(15'(cw * pd)) + 16'd31) >> 5) << 2);
          mstride <= 6'(((10'(cw) + 10'd31) >> 5) << 2);
          base    <= pal + ncol4;
          state   <= S_PB;
        end

        S_PB: begin
          prod  <= EW'(row * stride);
          state <= S_PC;
        end

        S_PC: begin
          bcnt  <= '0;
          state <= S_FETCH;
          priority if (pd == 6'd32) begin
            addr <= rp + EW'({px, 2'b00});
            ret  <= X_PIX;
          end else if (pd == 6'd24) begin
            addr <= rp + EW'({px, 1'b0}) + EW'(px);
            ret  <= X_PIX;
          end else if (pd == 6'd8) begin
            addr <= rp + EW'(px);
            ret  <= X_IDX;
          end else if (pd == 6'd4) begin
            addr <= rp + EW'(px[7:1]);
            ret  <= X_IDX;
          end else begin
            addr <= rp + EW'(px[7:3]);
            ret  <= X_IDX;
          end
        end

        S_MA: begin
          prod  <= EW'(stride * ch);
          state <= S_MB;
        end

        S_MB: begin
          mbase <= base + prod;
          prod  <= EW'(row * mstride);
          state <= S_MC;
        end

        S_MC: begin
          addr  <= mbase + prod + EW'(px[7:3]);
          ret   <= X_MASK;
          state <= S_FETCH;
        end

        S_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            status       <= res_st;
            image_width  <= cw;
            image_height <= ch;
            data_length  <= cl[18:0];
            red          <= pix_ok ? pr  : 8'd0;
            green        <= pix_ok ? pg  : 8'd0;
            blue         <= pix_ok ? pbl : 8'd0;
            alpha        <= pix_ok ? pa  : 8'd0;
            png_byte     <= png_ok ? pngb : 8'd0;
            state        <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_lc_bound: assert property (@(posedge clk) disable iff (rst)
    lc <= LW'(MAX_FILE_BYTES))
    else $error("load count beyond store depth");

  a_data_after_fetch: assert property (@(posedge clk) disable iff (rst)
    (state == S_DATA) |-> ($past(state) == S_FETCH))
    else $error("store data used without a fetch");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second input transfer while an item is in work");

  a_failed_cleared: assert property (@(posedge clk) disable iff (rst)
    (ds != ST_BMP && ds != ST_PNG) |-> (cw == 9'd0 && cl == '0))
    else $error("chosen image kept after a failed parse");
`endif

endmodule

[rtl/icobd_store.sv]
// icobd_store: byte store for the loaded icon file, one write and one registered read port
// no dependencies; instantiated by ico_bitmap_decoder
module icobd_store #(
  parameter int DEPTH = 262144,
  parameter int AW    = 18
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[tb/sv/ico_bitmap_decoder_chk.sv]
// ico_bitmap_decoder_chk: watches both channels of the icon decoder, predicts each result
// from its own copy of the file store and directory state, and compares field by field
// depends on icobd_pkg
module ico_bitmap_decoder_chk import icobd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  action,
  input  logic [7:0]  file_byte,
  input  logic        final_byte,
  input  logic [7:0]  pixel_x,
  input  logic [7:0]  pixel_y,
  input  logic [17:0] resource_index,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  status,
  input  logic [8:0]  image_width,
  input  logic [8:0]  image_height,
  input  logic [18:0] data_length,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic [7:0]  alpha,
  input  logic [7:0]  png_byte,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_t     status;
    logic [8:0]  width;
    logic [8:0]  height;
    logic [18:0] length;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [7:0]  png_byte;
  } pixel_reply_t;

  localparam logic [7:0] PNG_MAGIC [8] = '{8'h89, 8'h50, 8'h4E, 8'h47,
                                           8'h0D, 8'h0A, 8'h1A, 8'h0A};

  logic [7:0]  file_mem [DEF_MAX_FILE_BYTES];
  int unsigned bytes_held;
  int unsigned pick_w, pick_h, pick_off, pick_len, bit_depth;
  bit          has_mask, file_closed;
  status_t     icon_state;
  pixel_reply_t replies_due [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic bit fetch8(input longint a, output logic [7:0] v);
    v = 8'd0;
    if (a >= longint'(bytes_held)) return 1'b0;
    v = file_mem[a];
    return 1'b1;
  endfunction

  function automatic bit fetch16(input longint a, output int unsigned v);
    logic [7:0] lo, hi;
    bit ok;
    ok = fetch8(a, lo) && fetch8(a + 1, hi);
    v = ok ? {16'd0, hi, lo} : 0;
    return ok;
  endfunction

  function automatic bit fetch32(input longint a, output int unsigned v);
    int unsigned lo, hi;
    bit ok;
    ok = fetch16(a, lo) && fetch16(a + 2, hi);
    v = ok ? (lo | (hi << 16)) : 0;
    return ok;
  endfunction

  function automatic void drop_choice();
    pick_w = 0; pick_h = 0; pick_off = 0; pick_len = 0;
    bit_depth = 0; has_mask = 1'b0;
  endfunction

  function automatic status_t parse_directory();
    int unsigned rsv, typ, cnt, w, h, area, best, off, len, bw, bh, d, bih, eo, el;
    logic [7:0] b8, w8, h8;
    longint e;
    bit is_png;
    best = 0; off = 0; len = 0; bw = 0; bh = 0;
    if (!fetch16(0, rsv) || !fetch16(2, typ) || !fetch16(4, cnt)) return ST_RANGE;
    if (rsv != 0 || typ != 1 || cnt == 0 || cnt > DEF_MAX_ICONS) return ST_BADHDR;
    for (int i = 0; i < cnt; i++) begin
      e = 6 + 16 * i;
      if (!fetch8(e, w8) || !fetch8(e + 1, h8) || !fetch32(e + 8, el) || !fetch32(e + 12, eo))
        return ST_RANGE;
      w = (w8 == 0) ? 256 : w8;
      h = (h8 == 0) ? 256 : h8;
      area = w * h;
      if (area > best) begin
        best = area; bw = w; bh = h; off = eo; len = el;
      end
    end
    if (off == 0) return ST_NOIMG;
    if (off >= bytes_held) return ST_RANGE;
    is_png = 1'b1;
    for (int i = 0; i < 8; i++) begin
      if (!fetch8(longint'(off) + i, b8)) return ST_RANGE;
      if (b8 != PNG_MAGIC[i]) is_png = 1'b0;
    end
    if (is_png) begin
      if (len == 0) return ST_NOIMG;
      if (longint'(off) + longint'(len) > longint'(bytes_held)) return ST_RANGE;
      pick_w = bw; pick_h = bh; pick_off = off; pick_len = len;
      return ST_PNG;
    end
    if (!fetch8(longint'(off) + 39, b8)) return ST_RANGE;
    void'(fetch32(longint'(off) + 8, bih));
    void'(fetch16(longint'(off) + 14, d));
    if (d != 32 && d != 24 && d != 8 && d != 4 && d != 1) return ST_DEPTH;
    pick_w = bw; pick_h = bh; pick_off = off;
    pick_len = bw * bh * 4;
    bit_depth = d;
    has_mask = (d < 32 && bih != bh);
    return ST_BMP;
  endfunction

  function automatic status_t fetch_pixel(input int unsigned x, input int unsigned y,
      output logic [7:0] rr, output logic [7:0] gg, output logic [7:0] bb,
      output logic [7:0] aa);
    longint pal, ncol, base, stride, row, rp, p, mstride, mp;
    logic [7:0] v, idx;
    bit ok;
    rr = 0; gg = 0; bb = 0; aa = 8'hFF; v = 0; idx = 0;
    pal    = longint'(pick_off) + 40;
    ncol   = (bit_depth <= 8) ? (longint'(1) << bit_depth) : 0;
    base   = pal + 4 * ncol;
    stride = ((longint'(pick_w) * bit_depth + 31) / 32) * 4;
    row    = longint'(pick_h) - 1 - y;
    rp     = base + row * stride;
    if (bit_depth == 32 || bit_depth == 24) begin
      p  = rp + longint'(x) * (bit_depth / 8);
      ok = fetch8(p, bb) && fetch8(p + 1, gg) && fetch8(p + 2, rr);
      if (ok && bit_depth == 32) ok = fetch8(p + 3, aa);
    end else begin
      if (bit_depth == 8) begin
        ok = fetch8(rp + x, idx);
      end else if (bit_depth == 4) begin
        ok  = fetch8(rp + x / 2, v);
        idx = (x & 1) ? (v & 8'h0F) : (v >> 4);
      end else begin
        ok  = fetch8(rp + x / 8, v);
        idx = (v >> (7 - (x & 7))) & 8'h01;
      end
      // indexed depths look up a blue, green, red, pad palette entry
      if (ok) ok = fetch8(pal + 4 * idx, bb) && fetch8(pal + 4 * idx + 1, gg)
                   && fetch8(pal + 4 * idx + 2, rr);
    end
    if (ok && has_mask) begin
      mstride = ((longint'(pick_w) + 31) / 32) * 4;
      mp = base + stride * pick_h + row * mstride + x / 8;
      ok = fetch8(mp, v);
      if (ok && v[7 - (x & 7)]) aa = 8'd0;
    end
    if (!ok) begin
      rr = 0; gg = 0; bb = 0; aa = 0;
      return ST_RANGE;
    end
    return ST_BMP;
  endfunction

  function automatic pixel_reply_t decode_step(input logic [1:0] act, input logic [7:0] fb,
      input logic fin, input logic [7:0] x, input logic [7:0] y, input logic [17:0] ri);
    pixel_reply_t r;
    logic [7:0] v;
    r = '0;
    if (act == A_LOAD) begin
      if (file_closed) begin
        bytes_held = 0;
        drop_choice();
        icon_state  = ST_NOIMG;
        file_closed = 1'b0;
      end
      if (bytes_held < DEF_MAX_FILE_BYTES) begin
        file_mem[bytes_held] = fb;
        bytes_held++;
        r.status = ST_ACCEPT;
      end else begin
        r.status = ST_RANGE;
      end
      if (fin) begin
        drop_choice();
        icon_state = parse_directory();
        if (icon_state > ST_PNG) drop_choice();
        file_closed = 1'b1;
        r.status = icon_state;
      end
    end else if (act == A_PIX) begin
      if (icon_state != ST_BMP) r.status = (icon_state == ST_PNG) ? ST_NOIMG : icon_state;
      else if (x >= pick_w || y >= pick_h) r.status = ST_RANGE;
      else r.status = fetch_pixel(x, y, r.red, r.green, r.blue, r.alpha);
    end else if (act == A_PNG) begin
      if (icon_state != ST_PNG) begin
        r.status = (icon_state == ST_BMP) ? ST_NOIMG : icon_state;
      end else if (ri >= pick_len || !fetch8(longint'(pick_off) + ri, v)) begin
        r.status = ST_RANGE;
      end else begin
        r.status   = ST_PNG;
        r.png_byte = v;
      end
    end else begin
      r.status = ST_RANGE;
    end
    r.width  = pick_w[8:0];
    r.height = pick_h[8:0];
    r.length = pick_len[18:0];
    return r;
  endfunction

  task automatic report(input string what, input int got, input int want);
    $display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    pixel_reply_t want;
    if (rst) begin
      bytes_held  = 0;
      drop_choice();
      icon_state  = ST_NOIMG;
      file_closed = 1'b0;
      replies_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (replies_due.size() == 0) begin
          report("unexpected result transfer", status, -1);
        end else begin
          want = replies_due.pop_front();
          if (status != want.status) report("status", status, want.status);
          if (image_width != want.width) report("image_width", image_width, want.width);
          if (image_height != want.height) report("image_height", image_height, want.height);
          if (data_length != want.length) report("data_length", data_length, want.length);
          if (red != want.red) report("red", red, want.red);
          if (green != want.green) report("green", green, want.green);
          if (blue != want.blue) report("blue", blue, want.blue);
          if (alpha != want.alpha) report("alpha", alpha, want.alpha);
          if (png_byte != want.png_byte) report("png_byte", png_byte, want.png_byte);
        end
      end
      if (in_valid && in_ready)
        replies_due.push_back(decode_step(action, file_byte, final_byte, pixel_x, pixel_y,
                                          resource_index));
    end
    pending = replies_due.size();
  end

endmodule

[tb/sv/ico_bitmap_decoder_tb.sv]
// ico_bitmap_decoder_tb: builds icon files (bitmaps of every depth, png resources, broken
// files), streams them into the decoder, reads pixels and png bytes back, gives the verdict
// depends on icobd_pkg, ico_bitmap_decoder and ico_bitmap_decoder_chk
module ico_bitmap_decoder_tb import icobd_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam action_t A_NONE = 2'd3;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int HOLD_CYCLES = 400;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  action = A_LOAD;
  logic [7:0]  file_byte = 8'd0;
  logic        final_byte = 1'b0;
  logic [7:0]  pixel_x = 8'd0;
  logic [7:0]  pixel_y = 8'd0;
  logic [17:0] resource_index = 18'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [8:0]  image_width, image_height;
  logic [18:0] data_length;
  logic [7:0]  red, green, blue, alpha, png_byte;
  int          fail_count, pending;

  int  send_idle = 14;
  int  recv_idle = 83;
  bit  hold_req  = 1'b0;
  int  hold_left = 0;
  int  cycle_cnt = 0;
  logic [7:0] icon_file [$];

  ico_bitmap_decoder dut (.*);

  ico_bitmap_decoder_chk chk (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic send(input action_t act, input logic [7:0] fb, input bit fin,
      input logic [7:0] x, input logic [7:0] y, input logic [17:0] ri);
    bit took;
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    action         <= act;
    file_byte      <= fb;
    final_byte     <= fin;
    pixel_x        <= x;
    pixel_y        <= y;
    resource_index <= ri;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
  endtask

  task automatic read_pixel(input int x, input int y);
    send(A_PIX, 8'($urandom), 1'($urandom), 8'(x), 8'(y), 18'($urandom));
  endtask

  task automatic read_png(input int ri);
    send(A_PNG, 8'($urandom), 1'($urandom), 8'($urandom), 8'($urandom), 18'(ri));
  endtask

  task automatic stream_file();
    for (int i = 0; i < icon_file.size(); i++)
      send(A_LOAD, icon_file[i], i == icon_file.size() - 1, 8'($urandom), 8'($urandom),
           18'($urandom));
  endtask

  task automatic put16(input int v);
    icon_file.push_back(v[7:0]);
    icon_file.push_back(v[15:8]);
  endtask

  task automatic put32(input int v);
    put16(int'(v[15:0]));
    put16(int'(v[31:16]));
  endtask

  task automatic put_random(input int n);
    repeat (n) icon_file.push_back(8'($urandom));
  endtask

  task automatic put_dir(input int rsv, input int typ, input int n);
    icon_file.delete();
    put16(rsv);
    put16(typ);
    put16(n);
  endtask

  // directory entry: 256 is written as a zero size byte
  task automatic put_entry(input int w, input int h, input int len, input int off);
    icon_file.push_back(w[7:0]);
    icon_file.push_back(h[7:0]);
    put16(0);
    put16(1);
    put16(0);
    put32(len);
    put32(off);
  endtask

  task automatic build_bmp(input int w, input int h, input int d, input bit masked,
      input int n, input int pick);
    int stride, mstride;
    stride  = ((w * d + 31) / 32) * 4;
    mstride = ((w + 31) / 32) * 4;
    put_dir(0, 1, n);
    for (int i = 0; i < n; i++)
      if (i == pick) put_entry(w, h, int'($urandom), 6 + 16 * n);
      else put_entry(1, 1, int'($urandom), int'($urandom));
    put32(40);
    put32(w);
    put32(masked ? 2 * h : h);
    put16(1);
    put16(d);
    put_random(24);
    if (d <= 8) put_random(4 << d);
    put_random(stride * h);
    if (masked) put_random(mstride * h);
  endtask

  task automatic build_png(input int n, input int pick, input int len, input int decl,
      input bit tie, input int sz);
    put_dir(0, 1, n);
    for (int i = 0; i < n; i++)
      if (i == pick) put_entry(sz, sz, decl, 6 + 16 * n);
      else if (tie) put_entry(sz, sz, decl, int'($urandom));
      else put_entry(3, 2, int'($urandom), int'($urandom));
    icon_file.push_back(8'h89); icon_file.push_back(8'h50);
    icon_file.push_back(8'h4E); icon_file.push_back(8'h47);
    icon_file.push_back(8'h0D); icon_file.push_back(8'h0A);
    icon_file.push_back(8'h1A); icon_file.push_back(8'h0A);
    put_random(len - 8);
  endtask

  task automatic random_reads(input int n);
    repeat (n) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4: read_pixel($urandom_range(5), $urandom_range(2));
        5:             read_pixel(int'($urandom), int'($urandom));
        6, 7:          read_png($urandom_range(30));
        8:             read_png(int'($urandom));
        default:       send(A_NONE, 8'($urandom), 1'($urandom), 8'($urandom), 8'($urandom),
                            18'($urandom));
      endcase
    end
  endtask

  task automatic random_file();
    int depth_opts [4] = '{32, 24, 4, 1};
    int n, len;
    n = $urandom_range(1, 2);
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5:
        build_bmp($urandom_range(1, 6), $urandom_range(1, 3), depth_opts[$urandom_range(3)],
                  1'($urandom), n, $urandom_range(n - 1));
      6, 7: begin
        len = $urandom_range(8, 24);
        build_png(n, $urandom_range(n - 1), len, $urandom_range(3) == 0 ? len + 2 : len, 0,
                  16);
      end
      8: begin
        build_bmp($urandom_range(1, 4), $urandom_range(1, 2), depth_opts[$urandom_range(3)],
                  1'($urandom), 1, 0);
        if ($urandom_range(1)) icon_file[$urandom_range(icon_file.size() - 1)] = 8'($urandom);
        else repeat ($urandom_range(1, icon_file.size() - 1)) void'(icon_file.pop_back());
      end
      default: begin
        icon_file.delete();
        put_random($urandom_range(1, 20));
      end
    endcase
    stream_file();
    random_reads($urandom_range(8, 12));
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // nothing loaded yet
    read_pixel(0, 0);
    read_png(0);
    send(A_NONE, 8'hFF, 1'b1, 8'hFF, 8'hFF, 18'h3FFFF);

    build_bmp(2, 1, 32, 0, 2, 1);
    stream_file();
    read_pixel(0, 0); read_pixel(1, 0); read_pixel(2, 0); read_pixel(0, 1);
    read_png(0);

    build_bmp(1, 1, 24, 1, 1, 0);
    stream_file();
    read_pixel(0, 0);

    // 8-bit header and the first palette bytes only: the pixels lie past the loaded bytes
    build_bmp(1, 1, 8, 0, 1, 0);
    while (icon_file.size() > 70) void'(icon_file.pop_back());
    stream_file();
    read_pixel(0, 0);

    build_bmp(3, 1, 4, 1, 1, 0);
    stream_file();
    read_pixel(2, 0); read_pixel(1, 0);

    send_idle = 83;
    recv_idle = 14;
    hold_req  = 1'b1;
    build_png(1, 0, 10, 0, 0, 16);
    stream_file();
    build_png(1, 0, 10, 40, 0, 16);
    stream_file();
    read_png(0);

    put_dir(1, 1, 1); put_entry(1, 1, 0, 22); stream_file();
    put_dir(0, 2, 1); put_entry(1, 1, 0, 22); stream_file();
    put_dir(0, 1, 0); stream_file();
    put_dir(0, 1, 21); stream_file();
    put_dir(0, 1, 1); put_entry(4, 4, 10, 0); stream_file();
    build_bmp(1, 1, 16, 0, 1, 0); stream_file();
    read_pixel(0, 0);
    icon_file.delete(); put_random(3); stream_file();
    icon_file.delete(); put_random(1); stream_file();

    send_idle = 0;
    recv_idle = 0;
    // both entries 256 by 256 as zero size bytes; the first must win
    build_png(2, 0, 10, 10, 1, 256);
    stream_file();
    read_png(0); read_png(9); read_png(10); read_png(18'h3FFFF); read_pixel(0, 0);

    build_bmp(9, 1, 1, 1, 1, 0);
    stream_file();
    read_pixel(8, 0); read_pixel(3, 0);

    random_file();

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
